// File: sv/phist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Photon histogram package
// Shared constants, operation codes and the result and request types.
// ----------------------------------------------------------------------------
package phist_pkg;

  localparam int XPIX_DEF = 80;
  localparam int YPIX_DEF = 125;

  localparam int CW = 10;
  localparam int PW = 20;

  localparam logic [1:0] OP_WORD  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0]  HEADER_MARK   = 8'hFF;
  localparam logic [7:0]  MAX_WORDS_RST = 8'd110;
  localparam logic [7:0]  WORDS_SAT     = 8'hFF;
  localparam logic [23:0] PKT_MAX       = 24'hFFFFFF;

  typedef struct packed {
    logic        photon_counted;
    logic        header_seen;
    logic        too_long;
    logic [7:0]  header_roach;
    logic [11:0] header_frame;
    logic [35:0] header_timestamp;
    logic [15:0] pixel_count;
    logic [23:0] packet_count;
  } res_t;

  typedef struct packed {
    logic write;
    logic read;
    logic clear;
    res_t res;
  } req_t;

endpackage

// File: sv/photon_event_image_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Photon event image histogram
// Parses readout words, counts photons per pixel and reports packet headers.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    in_valid / in_ready    op, word, read_x, read_y
//  output   out_valid / out_ready  photon_counted .. packet_count
//  config   cfg_write              cfg_data (max_packet_words)
//
// One transfer is taken per cycle while in_ready is high; its result passes
// the address register and the RAM read stage into the output register.
// Back-to-back updates of the same pixel are forwarded from the write stage.
// After reset and after every end-of-second clear, a sweep writes zero to all
// XPIX*YPIX counters (10000 by default) while in_ready stays low.
// A full output register that is not taken halts the whole pipeline.
// ----------------------------------------------------------------------------
module photon_event_image_histogram #(
  parameter int XPIX = phist_pkg::XPIX_DEF,
  parameter int YPIX = phist_pkg::YPIX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] word,
  input  logic [6:0]  read_x,
  input  logic [6:0]  read_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        photon_counted,
  output logic        header_seen,
  output logic        too_long,
  output logic [7:0]  header_roach,
  output logic [11:0] header_frame,
  output logic [35:0] header_timestamp,
  output logic [15:0] pixel_count,
  output logic [23:0] packet_count,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data
);

  import phist_pkg::*;

  localparam int AW = ((XPIX * YPIX) > 1) ? $clog2(XPIX * YPIX) : 1;

  logic          accept;
  req_t          req;
  logic [AW-1:0] req_idx;
  res_t          out_res;

  assign accept = in_valid && in_ready;

  phist_front #(
    .XPIX (XPIX),
    .YPIX (YPIX),
    .AW   (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .word      (word),
    .read_x    (read_x),
    .read_y    (read_y),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req),
    .req_idx   (req_idx)
  );

  phist_rmw #(
    .XPIX (XPIX),
    .YPIX (YPIX),
    .AW   (AW)
  ) u_rmw (
    .clk       (clk),
    .rst       (rst),
    .req_valid (accept),
    .req       (req),
    .req_idx   (req_idx),
    .take_ok   (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign photon_counted   = out_res.photon_counted;
  assign header_seen      = out_res.header_seen;
  assign too_long         = out_res.too_long;
  assign header_roach     = out_res.header_roach;
  assign header_frame     = out_res.header_frame;
  assign header_timestamp = out_res.header_timestamp;
  assign pixel_count      = out_res.pixel_count;
  assign packet_count     = out_res.packet_count;

  a_clear_blocks : assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_CLEAR)) |=> !in_ready)
    else $error("input taken right after a clear transfer");

  a_reset_sweep : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input taken before the reset sweep");

  a_one_kind : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({photon_counted, header_seen}))
    else $error("result is both photon and header");

  a_long_hdr : assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_long) |-> header_seen)
    else $error("too_long without a header");

endmodule

// File: sv/phist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Photon histogram RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module phist_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/phist_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Photon histogram front end
// Decodes each transfer, tracks packet state and forms the pixel address.
// ----------------------------------------------------------------------------
module phist_front #(
  parameter int XPIX = phist_pkg::XPIX_DEF,
  parameter int YPIX = phist_pkg::YPIX_DEF,
  parameter int AW   = ((XPIX * YPIX) > 1) ? $clog2(XPIX * YPIX) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        op,
  input  logic [63:0]       word,
  input  logic [6:0]        read_x,
  input  logic [6:0]        read_y,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  output phist_pkg::req_t   req,
  output logic [AW-1:0]     req_idx
);

  import phist_pkg::*;

  logic [7:0]    max_packet_words;
  logic [7:0]    words_in_packet;
  logic          inside_packet;
  logic [23:0]   packets_this_second;

  logic          hdr;
  logic [CW-1:0] wx;
  logic [CW-1:0] wy;
  logic [CW-1:0] sel_x;
  logic [CW-1:0] sel_y;
  logic          w_in;
  logic          r_in;
  logic [PW-1:0] prod;

  assign hdr = (word[63:56] == HEADER_MARK);
  assign wx  = word[63:54];
  assign wy  = word[53:44];
  assign w_in = (wx < CW'(XPIX)) && (wy < CW'(YPIX));
  assign r_in = (CW'(read_x) < CW'(XPIX)) && (CW'(read_y) < CW'(YPIX));
  assign sel_x = (op == OP_READ) ? CW'(read_x) : wx;
  assign sel_y = (op == OP_READ) ? CW'(read_y) : wy;
  assign prod  = PW'(sel_x) * PW'(YPIX) + PW'(sel_y);
  assign req_idx = prod[AW-1:0];

  always_comb begin
    req = '0;
    case (op)
      OP_WORD: begin
        if (hdr) begin
          req.res.header_seen      = 1'b1;
          req.res.too_long         = inside_packet && (words_in_packet > max_packet_words);
          req.res.header_roach     = word[55:48];
          req.res.header_frame     = word[47:36];
          req.res.header_timestamp = word[35:0];
        end else if (inside_packet && w_in) begin
          req.write              = 1'b1;
          req.res.photon_counted = 1'b1;
        end
      end
      OP_READ: begin
        req.read = r_in;
      end
      OP_CLEAR: begin
        req.clear            = 1'b1;
        req.res.packet_count = packets_this_second;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_words    <= MAX_WORDS_RST;
      words_in_packet     <= '0;
      inside_packet       <= 1'b0;
      packets_this_second <= '0;
    end else begin
      if (cfg_write) begin
        max_packet_words <= cfg_data;
      end
      if (accept) begin
        if (op == OP_WORD) begin
          if (hdr) begin
            inside_packet   <= 1'b1;
            words_in_packet <= 8'd1;
            if (packets_this_second != PKT_MAX) begin
              packets_this_second <= packets_this_second + 24'd1;
            end
          end else if (inside_packet && (words_in_packet != WORDS_SAT)) begin
            words_in_packet <= words_in_packet + 8'd1;
          end
        end else if (op == OP_CLEAR) begin
          packets_this_second <= '0;
        end
      end
    end
  end

endmodule

// File: sv/phist_rmw.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Photon histogram read-modify-write engine
// Two-stage counter update with forwarding, output register and clear sweep.
// ----------------------------------------------------------------------------
module phist_rmw #(
  parameter int XPIX = phist_pkg::XPIX_DEF,
  parameter int YPIX = phist_pkg::YPIX_DEF,
  parameter int AW   = ((XPIX * YPIX) > 1) ? $clog2(XPIX * YPIX) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  phist_pkg::req_t req,
  input  logic [AW-1:0]   req_idx,
  output logic            take_ok,
  output logic            out_valid,
  input  logic            out_ready,
  output phist_pkg::res_t out_res
);

  import phist_pkg::*;

  localparam int NPIX = XPIX * YPIX;

  logic          adv;
  logic          a_valid;
  req_t          a_req;
  logic [AW-1:0] a_idx;
  logic          b_valid;
  req_t          b_req;
  logic [AW-1:0] b_idx;
  logic          byp_hit;
  logic [15:0]   byp_data;
  logic [15:0]   rdata;
  logic [15:0]   cur;
  logic [15:0]   b_new;
  logic          clearing;
  logic          clr_pend;
  logic [AW-1:0] clr_cnt;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  res_t          out_next;

  assign adv     = !out_valid || out_ready;
  assign take_ok = adv && !clearing && !clr_pend;
  assign cur     = byp_hit ? byp_data : rdata;
  assign b_new   = cur + 16'd1;
  assign we      = clearing || (adv && b_valid && b_req.write);
  assign waddr   = clearing ? clr_cnt : b_idx;
  assign wdata   = clearing ? 16'd0 : b_new;

  always_comb begin
    out_next = b_req.res;
    if (b_req.read) begin
      out_next.pixel_count = cur;
    end
  end

  phist_ram #(
    .WIDTH (16),
    .DEPTH (NPIX),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (a_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      a_req    <= req;
      a_idx    <= req_idx;
      b_req    <= a_req;
      b_idx    <= a_idx;
      byp_hit  <= b_valid && b_req.write && a_valid && (a_idx == b_idx);
      byp_data <= b_new;
      out_res  <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_pend  <= 1'b0;
      clr_cnt   <= '0;
    end else begin
      if (adv) begin
        a_valid   <= req_valid;
        b_valid   <= a_valid;
        out_valid <= b_valid;
      end
      if (req_valid && req.clear) begin
        clr_pend <= 1'b1;
      end
      if (clearing) begin
        if (clr_cnt == AW'(NPIX - 1)) begin
          clearing <= 1'b0;
          clr_pend <= 1'b0;
        end else begin
          clr_cnt <= clr_cnt + AW'(1);
        end
      end else if (adv && b_valid && b_req.clear) begin
        clearing <= 1'b1;
        clr_cnt  <= '0;
      end
    end
  end

endmodule
